// ===== design/llpuf_pkg.sv =====
package llpuf_pkg;

    localparam int MAX_NODES   = 1024;
    localparam int LENGTH_BITS = 30;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NOP   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_EDGE_RD,
        S_EDGE_WAIT,
        S_EDGE_CHK,
        S_FIND_RD,
        S_FIND_WAIT,
        S_FIND_STEP,
        S_COMP_RD,
        S_COMP_WAIT,
        S_COMP_STEP,
        S_UNITE_RD,
        S_UNITE_WAIT,
        S_UNITE_WR,
        S_ANSWER,
        S_OUT
    } t_state;

endpackage

// ===== design/llpuf_if.sv =====
interface llpuf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [9:0]  node_a;
    logic [9:0]  node_b;
    logic [29:0] edge_length;
    logic [29:0] query_limit;
    logic [15:0] query_tag;
    modport source (output valid, action, node_a, node_b, edge_length, query_limit,
                    query_tag, input ready);
    modport sink (input valid, action, node_a, node_b, edge_length, query_limit,
                  query_tag, output ready);
endinterface

interface llpuf_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] answer_tag;
    logic        connected;
    logic [1:0]  status;
    modport source (output valid, answer_tag, connected, status, input ready);
    modport sink (input valid, answer_tag, connected, status, output ready);
endinterface

interface llpuf_cfg_if;
    logic        valid;
    logic        ready;
    logic [10:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== design/limited_length_path_union_find_unit.sv =====
// Channel   Direction  Payload
// in_ch     sink       action, node_a, node_b, edge_length, query_limit, query_tag
// out_ch    source     answer_tag, connected, status
// cfg_ch    sink       node_count (11 bits)
//
// After reset and after every clear transaction a pass over every node
// rewrites the parent and size memories; no input is accepted meanwhile.
// A load or a no-op is handled in the idle state. A query walks the stored
// edges in order; a root search follows parent reads and compression rewrites
// each node on the chain, for both ends of every consumed edge and both query
// nodes; two different roots are then united, and the answer is registered.
// One item is in flight at a time; input stalls while a result waits.
module limited_length_path_union_find_unit
    import llpuf_pkg::*;
#(
    parameter int MAX_EDGES = 4096
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    llpuf_in_if.sink     in_ch,
    llpuf_out_if.source  out_ch,
    llpuf_cfg_if.sink    cfg_ch
);
    localparam int NW = $clog2(MAX_NODES);
    localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int SW = $clog2(MAX_NODES + 1);
    localparam int KW = $clog2(MAX_NODES + 1) + 1;

    // Memories
    logic [NW-1:0]          parent_mem [MAX_NODES];
    logic [SW-1:0]          size_mem   [MAX_NODES];
    logic [2*NW+LENGTH_BITS-1:0] edge_mem [MAX_EDGES];

    t_state r_state, n_state;
    logic [10:0] r_node_count;
    logic [CW-1:0] r_fill, r_cons;
    logic [NW-1:0] r_init_idx;

    logic [NW-1:0] r_qa, r_qb;
    logic [LENGTH_BITS-1:0] r_lim;
    logic [15:0] r_tag;
    logic r_query;            // 1 when the walk is for the query answer

    logic [NW-1:0] r_eb;
    logic          r_side;    // which endpoint is being resolved
    logic [NW-1:0] r_x, r_cur, r_root, r_ra;
    logic [KW-1:0] r_steps;
    logic [SW-1:0] r_sza;

    logic [NW-1:0] par_rd;
    logic [SW-1:0] size_rd;
    logic [2*NW+LENGTH_BITS-1:0] edge_rd;

    logic          par_we, size_we;
    logic [NW-1:0] par_waddr, par_wdata, par_raddr, size_waddr, size_raddr;
    logic [SW-1:0] size_wdata;

    logic r_ovalid;
    logic [15:0] r_otag;
    logic r_oconn;
    logic [1:0] r_ostat;

    logic [11:0] eff_cnt;
    logic in_acc, a_bad, b_bad;

    assign eff_cnt = (12'(r_node_count) < 12'(MAX_NODES)) ? 12'(r_node_count)
                                                          : 12'(MAX_NODES);
    assign a_bad  = (12'(in_ch.node_a) >= eff_cnt) || (32'(in_ch.node_a) >= MAX_NODES);
    assign b_bad  = (12'(in_ch.node_b) >= eff_cnt) || (32'(in_ch.node_b) >= MAX_NODES);
    assign in_ch.ready  = (r_state == S_IDLE) && !r_ovalid;
    assign in_acc       = in_ch.valid && in_ch.ready;
    assign cfg_ch.ready = 1'b1;

    assign out_ch.valid      = r_ovalid;
    assign out_ch.answer_tag = r_otag;
    assign out_ch.connected  = r_oconn;
    assign out_ch.status     = r_ostat;

    always_ff @(posedge i_clk) begin
        if (par_we) begin
            parent_mem[par_waddr] <= par_wdata;
        end
        par_rd <= parent_mem[par_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (size_we) begin
            size_mem[size_waddr] <= size_wdata;
        end
        size_rd <= size_mem[size_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && t_action'(in_ch.action) == ACT_LOAD && !a_bad && !b_bad
            && r_fill < CW'(MAX_EDGES)) begin
            edge_mem[r_fill[EW-1:0]] <= {in_ch.node_a[NW-1:0], in_ch.node_b[NW-1:0],
                                         in_ch.edge_length[LENGTH_BITS-1:0]};
        end
        edge_rd <= edge_mem[r_cons[EW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Walk control. A root search follows parents from r_x; compression then
    // rewrites every node on the chain to the root found.
    always_comb begin
        n_state    = r_state;
        par_we     = 1'b0;
        par_waddr  = r_cur;
        par_wdata  = r_root;
        par_raddr  = r_cur;
        size_we    = 1'b0;
        size_waddr = r_root;
        size_wdata = r_sza;
        size_raddr = r_ra;
        unique case (r_state)
            S_INIT: begin
                par_we     = 1'b1;
                par_waddr  = r_init_idx;
                par_wdata  = r_init_idx;
                size_we    = 1'b1;
                size_waddr = r_init_idx;
                size_wdata = SW'(1);
                if (32'(r_init_idx) == MAX_NODES - 1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    case (t_action'(in_ch.action))
                        ACT_QUERY: n_state = (a_bad || b_bad) ? S_IDLE : S_EDGE_RD;
                        ACT_CLEAR: n_state = S_INIT;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_EDGE_RD:   n_state = S_EDGE_WAIT;
            S_EDGE_WAIT: n_state = S_EDGE_CHK;
            S_EDGE_CHK:  n_state = S_FIND_RD;
            S_FIND_RD:   n_state = S_FIND_WAIT;
            S_FIND_WAIT: n_state = S_FIND_STEP;
            S_FIND_STEP: begin
                if (par_rd == r_cur || 32'(r_steps) >= MAX_NODES) begin
                    n_state = S_COMP_RD;
                end else begin
                    n_state = S_FIND_WAIT;
                    par_raddr = par_rd;
                end
            end
            S_COMP_RD: begin
                if (r_cur == r_root || 32'(r_steps) >= MAX_NODES) begin
                    n_state = r_side ? (r_query ? S_ANSWER : S_UNITE_RD) : S_FIND_RD;
                end else begin
                    n_state = S_COMP_WAIT;
                end
            end
            S_COMP_WAIT: n_state = S_COMP_STEP;
            S_COMP_STEP: begin
                par_we  = 1'b1;
                n_state = S_COMP_RD;
            end
            S_UNITE_RD: begin
                n_state = (r_ra == r_root) ? S_EDGE_RD : S_UNITE_WAIT;
            end
            S_UNITE_WAIT: begin
                size_raddr = r_root;
                n_state = S_UNITE_WR;
            end
            S_UNITE_WR: begin
                // r_sza holds the first root's size, size_rd the second's.
                par_we = 1'b1;
                size_we = 1'b1;
                size_wdata = r_sza + size_rd;
                if (r_sza < size_rd) begin
                    par_waddr = r_ra;
                    par_wdata = r_root;
                    size_waddr = r_root;
                end else begin
                    par_waddr = r_root;
                    par_wdata = r_ra;
                    size_waddr = r_ra;
                end
                n_state = S_EDGE_RD;
            end
            S_ANSWER: n_state = S_OUT;
            S_OUT:    n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    logic [LENGTH_BITS-1:0] e_len;
    logic [NW-1:0] e_a, e_b;
    assign {e_a, e_b, e_len} = edge_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= 11'd1024;
            r_fill <= '0;
            r_cons <= '0;
            r_init_idx <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (cfg_ch.valid) begin
                r_node_count <= cfg_ch.data;
            end
            if (r_ovalid && out_ch.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_INIT: begin
                    r_init_idx <= r_init_idx + NW'(1);
                    r_fill <= '0;
                    r_cons <= '0;
                end
                S_IDLE: begin
                    r_init_idx <= '0;
                    if (in_acc) begin
                        r_qa <= in_ch.node_a[NW-1:0];
                        r_qb <= in_ch.node_b[NW-1:0];
                        r_lim <= in_ch.query_limit[LENGTH_BITS-1:0];
                        r_tag <= in_ch.query_tag;
                        r_query <= 1'b0;
                        case (t_action'(in_ch.action))
                            ACT_LOAD: begin
                                if (a_bad || b_bad) begin
                                    r_ovalid <= 1'b1;
                                    r_otag <= '0;
                                    r_oconn <= 1'b0;
                                    r_ostat <= ST_RANGE;
                                end else if (r_fill >= CW'(MAX_EDGES)) begin
                                    r_ovalid <= 1'b1;
                                    r_otag <= '0;
                                    r_oconn <= 1'b0;
                                    r_ostat <= ST_FULL;
                                end else begin
                                    r_fill <= r_fill + CW'(1);
                                end
                            end
                            ACT_QUERY: begin
                                if (a_bad || b_bad) begin
                                    r_ovalid <= 1'b1;
                                    r_otag <= in_ch.query_tag;
                                    r_oconn <= 1'b0;
                                    r_ostat <= ST_RANGE;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_EDGE_CHK: begin
                    r_side <= 1'b0;
                    if (r_cons < r_fill && e_len < r_lim) begin
                        r_cons <= r_cons + CW'(1);
                        r_eb <= e_b;
                        r_x <= e_a;
                    end else begin
                        r_query <= 1'b1;
                        r_eb <= r_qb;
                        r_x <= r_qa;
                    end
                end
                S_FIND_RD: begin
                    r_cur <= r_x;
                    r_steps <= '0;
                end
                S_FIND_STEP: begin
                    if (par_rd == r_cur || 32'(r_steps) >= MAX_NODES) begin
                        r_root <= r_cur;
                        r_cur <= r_x;
                        r_steps <= '0;
                    end else begin
                        r_cur <= par_rd;
                        r_steps <= r_steps + KW'(1);
                    end
                end
                S_COMP_RD: begin
                    if (r_cur == r_root || 32'(r_steps) >= MAX_NODES) begin
                        if (!r_side) begin
                            r_ra <= r_root;
                            r_side <= 1'b1;
                            r_x <= r_eb;
                        end
                    end
                end
                S_COMP_STEP: begin
                    r_cur <= par_rd;
                    r_steps <= r_steps + KW'(1);
                end
                S_UNITE_WAIT: r_sza <= size_rd;
                S_ANSWER: begin
                    r_ovalid <= 1'b1;
                    r_otag <= r_tag;
                    r_oconn <= (r_ra == r_root);
                    r_ostat <= ST_OK;
                end
                default: ;
            endcase
        end
    end

    // S_COMP_RD issues the read of r_cur's parent for the compression step.
    // S_UNITE_RD reads r_ra's size through the default size address.

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cons <= r_fill)
        else $error("consume pointer passed fill count");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(MAX_EDGES))
        else $error("fill count beyond store");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !out_ch.ready) |=> r_ovalid && $stable(r_otag))
        else $error("pending result lost");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ANSWER) |=> r_ovalid && r_ostat == ST_OK)
        else $error("answer not registered");
endmodule

// ===== tb/llpuf_connectivity_checker.sv =====
module llpuf_connectivity_checker
    import llpuf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    llpuf_in_if   in_ch,
    llpuf_out_if  out_ch,
    llpuf_cfg_if  cfg_ch,
    output int    o_mismatches,
    output int    o_pending
);

    localparam int NODES = 1024;
    localparam int EDGES = 4096;

    typedef struct packed {
        logic [15:0] tag;
        logic        connected;
        t_status     status;
    } t_answer;

    typedef struct packed {
        logic [9:0]  a;
        logic [9:0]  b;
        logic [29:0] len;
    } t_edge;

    logic [9:0]  parent_of [NODES];
    logic [10:0] set_size  [NODES];
    t_edge       edge_list [EDGES];
    int          edges_loaded;
    int          edges_used;
    logic [10:0] node_count;
    t_answer     answers_due [$];
    int          mismatches;

    assign o_mismatches = mismatches;

    function automatic void add_answer(t_answer ans);
        answers_due.insert(answers_due.size(), ans);
    endfunction

    function automatic void empty_forest();
        for (int i = 0; i < NODES; i++) begin
            parent_of[i] = i[9:0];
            set_size[i]  = 11'd1;
        end
        edges_loaded = 0;
        edges_used   = 0;
    endfunction

    // Finds the root and then points every node on the walked chain straight at it.
    function automatic logic [9:0] root_of(logic [9:0] x);
        logic [9:0] r;
        logic [9:0] nx;
        r = x;
        while (parent_of[r] != r) r = parent_of[r];
        while (x != r) begin
            nx = parent_of[x];
            parent_of[x] = r;
            x = nx;
        end
        return r;
    endfunction

    function automatic void join_sets(logic [9:0] x, logic [9:0] y);
        logic [9:0] xr;
        logic [9:0] yr;
        logic [9:0] t;
        xr = root_of(x);
        yr = root_of(y);
        if (xr == yr) return;
        // On equal sizes the second endpoint's root goes under the first.
        if (set_size[xr] < set_size[yr]) begin
            t = xr;
            xr = yr;
            yr = t;
        end
        parent_of[yr] = xr;
        set_size[xr] = set_size[xr] + set_size[yr];
    endfunction

    function automatic void predict_item();
        int      in_use;
        t_answer ans;
        in_use = (node_count < NODES) ? node_count : NODES;
        ans = '{tag: 16'd0, connected: 1'b0, status: ST_OK};
        case (t_action'(in_ch.action))
            ACT_LOAD: begin
                if (in_ch.node_a >= in_use || in_ch.node_b >= in_use) begin
                    ans.status = ST_RANGE;
                    add_answer(ans);
                end else if (edges_loaded >= EDGES) begin
                    ans.status = ST_FULL;
                    add_answer(ans);
                end else begin
                    edge_list[edges_loaded] = '{in_ch.node_a, in_ch.node_b, in_ch.edge_length};
                    edges_loaded++;
                end
            end
            ACT_QUERY: begin
                ans.tag = in_ch.query_tag;
                if (in_ch.node_a >= in_use || in_ch.node_b >= in_use) begin
                    ans.status = ST_RANGE;
                end else begin
                    while (edges_used < edges_loaded &&
                           edge_list[edges_used].len < in_ch.query_limit) begin
                        join_sets(edge_list[edges_used].a, edge_list[edges_used].b);
                        edges_used++;
                    end
                    ans.connected = (root_of(in_ch.node_a) == root_of(in_ch.node_b));
                end
                add_answer(ans);
            end
            ACT_CLEAR: empty_forest();
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            empty_forest();
            node_count = 11'd1024;
            answers_due.delete();
            mismatches = 0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) node_count = cfg_ch.data;
            if (in_ch.valid && in_ch.ready) predict_item();
            if (out_ch.valid && out_ch.ready) begin
                if (answers_due.size() == 0) begin
                    $display("%0t: unexpected answer tag=%0h connected=%0b status=%0d", $time,
                             out_ch.answer_tag, out_ch.connected, out_ch.status);
                    mismatches++;
                end else begin
                    want = answers_due.pop_front();
                    if (out_ch.answer_tag !== want.tag) begin
                        $display("%0t: answer_tag expected %0h actual %0h", $time,
                                 want.tag, out_ch.answer_tag);
                        mismatches++;
                    end
                    if (out_ch.connected !== want.connected) begin
                        $display("%0t: connected expected %0b actual %0b (tag %0h)", $time,
                                 want.connected, out_ch.connected, want.tag);
                        mismatches++;
                    end
                    if (out_ch.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d (tag %0h)", $time,
                                 want.status, out_ch.status, want.tag);
                        mismatches++;
                    end
                end
            end
        end
        o_pending = answers_due.size();
    end

endmodule

// ===== tb/limited_length_path_union_find_unit_test.sv =====
module limited_length_path_union_find_unit_test;
    import llpuf_pkg::*;

    localparam int STALL_LIMIT = 500000;
    localparam logic [29:0] LEN_MAX = 30'h3FFF_FFFF;

    logic i_clk;
    logic i_rst_n;
    int   mismatches;
    int   pending;
    int   quiet_cycles = 0;
    bit   no_idling;
    int   hold_requests = 0;

    llpuf_in_if  in_ch ();
    llpuf_out_if out_ch ();
    llpuf_cfg_if cfg_ch ();

    limited_length_path_union_find_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .cfg_ch  (cfg_ch)
    );

    llpuf_connectivity_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .cfg_ch       (cfg_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // A clear sweeps every node and a query can consume the whole edge store,
    // so the watchdog is generous.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int holds_served;
        holds_served = 0;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_requests != holds_served) begin
                out_ch.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                holds_served = holds_served + 1;
            end else if (!no_idling && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    task automatic send_item(t_action act, logic [9:0] a, logic [9:0] b,
                             logic [29:0] len, logic [29:0] lim, logic [15:0] tag);
        if (!no_idling && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.action      <= act;
        in_ch.node_a      <= a;
        in_ch.node_b      <= b;
        in_ch.edge_length <= len;
        in_ch.query_limit <= lim;
        in_ch.query_tag   <= tag;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // The block raises ready only when it is idle with no result waiting, so
    // ready together with an empty prediction queue means nothing is in flight.
    task automatic drain_and_settle();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0 || !in_ch.ready);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic set_node_count(logic [10:0] value);
        drain_and_settle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [9:0] pick_node(int in_use);
        if (in_use == 0 || $urandom_range(0, 99) < 8) return 10'($urandom_range(0, 1023));
        return 10'($urandom_range(0, in_use - 1));
    endfunction

    task automatic random_phase(int items, int in_use, int shift);
        logic [30:0] cur_len;
        logic [30:0] cur_lim;
        logic [30:0] cand;
        logic [30:0] dec;
        int          pick;
        logic [15:0] tag;
        send_item(ACT_CLEAR, 0, 0, 0, 0, 0);
        cur_len = 31'($urandom_range(0, 1000) << shift);
        cur_lim = 0;
        for (int n = 0; n < items; n++) begin
            pick = $urandom_range(0, 99);
            tag = 16'($urandom());
            if (cur_len > 31'(LEN_MAX)) cur_len = 31'(LEN_MAX);
            if (pick < 45) begin
                if ($urandom_range(0, 19) == 0) begin
                    send_item(ACT_LOAD, pick_node(in_use), pick_node(in_use),
                              30'($urandom()), 30'($urandom()), tag);
                end else begin
                    cur_len = cur_len + 31'($urandom_range(0, 7) << shift);
                    if (cur_len > 31'(LEN_MAX)) cur_len = 31'(LEN_MAX);
                    send_item(ACT_LOAD, pick_node(in_use), pick_node(in_use),
                              cur_len[29:0], 30'($urandom()), tag);
                end
            end else if (pick < 87) begin
                if ($urandom_range(0, 19) == 0) begin
                    send_item(ACT_QUERY, pick_node(in_use), pick_node(in_use),
                              30'($urandom()), 30'($urandom()), tag);
                end else begin
                    cand = cur_len + 31'($urandom_range(0, 6) << shift);
                    dec  = 31'($urandom_range(0, 10) << shift);
                    cand = (cand > dec) ? cand - dec : 31'd0;
                    if (cand > 31'(LEN_MAX)) cand = 31'(LEN_MAX);
                    if (cand > cur_lim) cur_lim = cand;
                    send_item(ACT_QUERY, pick_node(in_use), pick_node(in_use),
                              30'($urandom()), cur_lim[29:0], tag);
                end
            end else if (pick < 92) begin
                send_item(ACT_CLEAR, 10'($urandom()), 10'($urandom()), 30'($urandom()),
                          30'($urandom()), tag);
                cur_len = 31'($urandom_range(0, 1000) << shift);
                cur_lim = 0;
            end else if (pick < 95) begin
                send_item(ACT_NOP, 10'($urandom()), 10'($urandom()), 30'($urandom()),
                          30'($urandom()), tag);
            end else begin
                send_item(t_action'($urandom_range(0, 3)), 10'($urandom()), 10'($urandom()),
                          30'($urandom()), 30'($urandom()), tag);
            end
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.action <= ACT_NOP;
        in_ch.node_a <= '0;
        in_ch.node_b <= '0;
        in_ch.edge_length <= '0;
        in_ch.query_limit <= '0;
        in_ch.query_tag   <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        no_idling = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed checks on a graph of eight nodes.
        set_node_count(11'd8);
        send_item(ACT_LOAD, 0, 1, 0, 0, 0);
        send_item(ACT_LOAD, 7, 6, 5, 0, 0);
        send_item(ACT_LOAD, 2, 3, LEN_MAX, 0, 0);
        send_item(ACT_LOAD, 1023, 0, 9, 0, 0);
        send_item(ACT_LOAD, 0, 8, 9, 0, 0);
        send_item(ACT_QUERY, 0, 1, 0, 0, 16'h0000);
        send_item(ACT_QUERY, 0, 1, 0, 1, 16'h0001);
        send_item(ACT_QUERY, 0, 7, 0, 6, 16'h0002);
        send_item(ACT_QUERY, 2, 3, 0, LEN_MAX, 16'h0003);
        send_item(ACT_QUERY, 7, 1023, 0, LEN_MAX, 16'h0004);
        send_item(ACT_QUERY, 8, 0, 0, LEN_MAX, 16'h0005);
        send_item(ACT_QUERY, 6, 7, 0, LEN_MAX, 16'hFFFF);
        send_item(ACT_NOP, 1023, 1023, LEN_MAX, LEN_MAX, 16'hFFFF);
        send_item(ACT_CLEAR, 0, 0, 0, 0, 0);
        send_item(ACT_QUERY, 0, 1, 0, LEN_MAX, 16'h0010);
        // Lengths out of order: consumption halts at the first long edge.
        send_item(ACT_LOAD, 4, 5, 100, 0, 0);
        send_item(ACT_LOAD, 5, 6, 10, 0, 0);
        send_item(ACT_QUERY, 4, 6, 0, 50, 16'h0011);
        send_item(ACT_QUERY, 4, 5, 0, 20, 16'h0012);
        send_item(ACT_QUERY, 4, 6, 0, 200, 16'h0013);
        send_item(ACT_LOAD, 0, 1, 300, 0, 0);
        send_item(ACT_LOAD, 4, 0, 301, 0, 0);
        send_item(ACT_LOAD, 1, 1, 302, 0, 0);
        send_item(ACT_QUERY, 6, 1, 0, 400, 16'h0014);

        // Load a burst of edges back to back, then consume the lot in one query.
        set_node_count(11'd16);
        send_item(ACT_CLEAR, 0, 0, 0, 0, 0);
        no_idling = 1'b1;
        for (int i = 0; i < 60; i++)
            send_item(ACT_LOAD, 10'($urandom_range(0, 15)), 10'($urandom_range(0, 15)),
                      30'(i), 0, 0);
        send_item(ACT_LOAD, 20, 3, 5000, 0, 0);
        send_item(ACT_QUERY, 0, 15, 0, LEN_MAX, 16'hA5A5);
        no_idling = 1'b0;

        set_node_count(11'd1024);
        random_phase(70, 1024, 20);
        set_node_count(11'd2);
        random_phase(60, 2, 0);
        set_node_count(11'd1);
        random_phase(30, 1, 3);
        set_node_count(11'd0);
        random_phase(25, 0, 10);
        set_node_count(11'd37);
        hold_requests = hold_requests + 1;
        random_phase(40, 37, 6);
        drain_and_settle();
        random_phase(50, 37, 26);
        set_node_count(11'd2047);
        random_phase(60, 1024, 12);
        set_node_count(11'd300);
        random_phase(60, 300, 2);
        set_node_count(11'd1024);
        no_idling = 1'b1;
        random_phase(80, 1024, 8);

        drain_and_settle();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
